// File: rtl/ppt_pkg.sv
package ppt_pkg;

  localparam int TABLE_SIZE = 16;
  localparam int SLOT_W = $clog2(TABLE_SIZE);
  localparam int CNT_W = $clog2(TABLE_SIZE + 1);
  localparam int ADDR_W = 48;
  localparam int TIME_W = 32;
  localparam logic [ADDR_W-1:0] BCAST_ADDR = {ADDR_W{1'b1}};
  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd30000;

  typedef enum logic [2:0] {
    OP_START  = 3'd0,
    OP_STOP   = 3'd1,
    OP_PAIR   = 3'd2,
    OP_DATA   = 3'd3,
    OP_REMOVE = 3'd4,
    OP_CLEAR  = 3'd5,
    OP_SWEEP  = 3'd6,
    OP_QUERY  = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_BUSY    = 3'd2,
    ST_BAD     = 3'd3,
    ST_UNPAIR  = 3'd4,
    ST_IGNORED = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    MODE_CLOSED = 2'd0,
    MODE_OPEN   = 2'd1,
    MODE_FULL   = 2'd2
  } mode_t;

  localparam logic [0:0] CFG_OWN_ADDR = 1'b0;
  localparam logic [0:0] CFG_TIMEOUT  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture a new item, start scan at slot 0
    logic scan;       // examine the current scan slot, advance
    logic finish;     // settle result, update global state
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;  // current slot is the last one
    logic need_scan;  // captured op walks the table
  } dp_sts_t;

  typedef struct packed {
    logic              send_valid;
    logic              send_broadcast;
    logic [ADDR_W-1:0] send_dest;
    logic [1:0]        send_step;
    logic [2:0]        status;
    logic [1:0]        pairing_state;
    logic [CNT_W-1:0]  peer_count;
    logic [3:0]        slot_out;
    logic [CNT_W-1:0]  removed_count;
    logic              slot_active;
  } result_t;

endpackage

// File: rtl/ppt_if.sv
interface ppt_in_if;
  import ppt_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        op;
  logic [ADDR_W-1:0] peer_address;
  logic [7:0]        msg_step;
  logic [7:0]        slot_in;
  logic [TIME_W-1:0] now_ms;
  modport source (output valid, op, peer_address, msg_step, slot_in, now_ms, input ready);
  modport sink (input valid, op, peer_address, msg_step, slot_in, now_ms, output ready);
endinterface

interface ppt_out_if;
  import ppt_pkg::*;
  logic              valid;
  logic              ready;
  logic              send_valid;
  logic              send_broadcast;
  logic [ADDR_W-1:0] send_dest;
  logic [1:0]        send_step;
  logic [2:0]        status;
  logic [1:0]        pairing_state;
  logic [4:0]        peer_count;
  logic [3:0]        slot_out;
  logic [4:0]        removed_count;
  logic              slot_active;
  modport source (output valid, send_valid, send_broadcast, send_dest, send_step, status,
                  pairing_state, peer_count, slot_out, removed_count, slot_active,
                  input ready);
  modport sink (input valid, send_valid, send_broadcast, send_dest, send_step, status,
                pairing_state, peer_count, slot_out, removed_count, slot_active,
                output ready);
endinterface

interface ppt_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/ppt_ctrl.sv
module ppt_ctrl
  import ppt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_FIN  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts.need_scan) begin
          state_nxt = S_FIN;
        end else begin
          cmd.scan = 1'b1;
          if (sts.scan_last) state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

// File: rtl/ppt_dp.sv
module ppt_dp
  import ppt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts,
  input  logic [2:0]        in_op,
  input  logic [ADDR_W-1:0] in_addr,
  input  logic [7:0]        in_step,
  input  logic [7:0]        in_slot,
  input  logic [TIME_W-1:0] in_now,
  input  logic [TIME_W-1:0] timeout,
  output result_t           res
);

  // per-entry flags in flops, payload in registers read at the scan or a named slot
  logic [TABLE_SIZE-1:0] paired_r, paired_nxt;
  logic [ADDR_W-1:0]     addr_r [TABLE_SIZE];
  logic [TIME_W-1:0]     seen_r [TABLE_SIZE];

  logic [2:0]        op_r;
  logic [ADDR_W-1:0] pa_r;
  logic [7:0]        ms_r;
  logic [7:0]        sl_r;
  logic [TIME_W-1:0] now_r;

  logic [SLOT_W-1:0] idx_r;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic              pon_r;
  logic [1:0]        hstep_r;
  logic [SLOT_W-1:0] pend_r;
  logic              pvalid_r;
  logic [1:0]        mode_r;
  // scan results
  logic              ff_found_r;
  logic [SLOT_W-1:0] ff_slot_r;
  logic              hit_r;
  logic [SLOT_W-1:0] hit_slot_r;
  logic [CNT_W-1:0]  rem_r;
  result_t           res_r, res_nxt;

  logic slot_ok;
  logic [SLOT_W-1:0] sidx;
  logic [TIME_W-1:0] age;
  logic              idx_act;
  logic              idx_drop;

  assign slot_ok = (sl_r < 8'(TABLE_SIZE));
  assign sidx = sl_r[SLOT_W-1:0];
  assign age = now_r - seen_r[idx_r];
  assign idx_act = age < timeout;
  assign idx_drop = paired_r[idx_r] &&
                    ((op_r == OP_CLEAR) || (op_r == OP_SWEEP && !idx_act));

  assign sts.need_scan = (op_r == OP_START) || (op_r == OP_PAIR) || (op_r == OP_DATA) ||
                         (op_r == OP_CLEAR) || (op_r == OP_SWEEP);
  assign sts.scan_last = (idx_r == SLOT_W'(TABLE_SIZE - 1));

  // mode and count come from live state, which holds while the result waits
  always_comb begin
    res = res_r;
    res.pairing_state = mode_r;
    res.peer_count = total_r;
  end

  logic [TIME_W-1:0] qage;
  assign qage = now_r - seen_r[sidx];

  always_comb begin
    paired_nxt = paired_r;
    total_nxt  = total_r;
    if (cmd.scan && idx_drop) begin
      paired_nxt[idx_r] = 1'b0;
      total_nxt = total_r - CNT_W'(1);
    end
  end

  // result of the captured event, taken at finish
  always_comb begin
    res_nxt = '0;
    case (op_r)
      OP_START: begin
        if (total_r >= CNT_W'(TABLE_SIZE)) begin
          res_nxt.status = ST_FULL;
        end else if (pon_r) begin
          res_nxt.status = ST_BUSY;
        end else begin
          if (ff_found_r) res_nxt.slot_out = 4'(ff_slot_r);
          res_nxt.send_valid = 1'b1; res_nxt.send_broadcast = 1'b1;
          res_nxt.send_dest = BCAST_ADDR; res_nxt.send_step = 2'd1;
        end
      end
      OP_STOP: res_nxt.status = ST_OK;
      OP_PAIR: begin
        if (!pon_r) begin
          res_nxt.status = ST_IGNORED;
        end else if (ms_r == 8'd1 && hstep_r == 2'd2) begin
          if (!pvalid_r) begin
            res_nxt.status = ST_FULL;
          end else begin
            res_nxt.send_valid = 1'b1; res_nxt.send_dest = pa_r;
            res_nxt.send_step = 2'd2; res_nxt.slot_out = 4'(pend_r);
          end
        end else if (ms_r == 8'd2 && hstep_r == 2'd3 && pvalid_r) begin
          res_nxt.send_valid = 1'b1; res_nxt.send_dest = addr_r[pend_r];
          res_nxt.send_step = 2'd3; res_nxt.slot_out = 4'(pend_r);
        end else begin
          res_nxt.status = ST_IGNORED;
        end
      end
      OP_DATA: begin
        if (hit_r) res_nxt.slot_out = 4'(hit_slot_r);
        else res_nxt.status = ST_IGNORED;
      end
      OP_REMOVE: begin
        res_nxt.slot_out = sl_r[3:0];
        if (!slot_ok) res_nxt.status = ST_BAD;
        else if (!paired_r[sidx]) res_nxt.status = ST_UNPAIR;
        else res_nxt.removed_count = CNT_W'(1);
      end
      OP_CLEAR: res_nxt.removed_count = rem_r;
      OP_SWEEP: res_nxt.removed_count = rem_r;
      default: begin
        res_nxt.slot_out = sl_r[3:0];
        if (!slot_ok) res_nxt.status = ST_BAD;
        else if (!paired_r[sidx]) res_nxt.status = ST_UNPAIR;
        else res_nxt.slot_active = (qage < timeout);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_op; pa_r <= in_addr; ms_r <= in_step; sl_r <= in_slot; now_r <= in_now;
    end
    if (cmd.finish && op_r == OP_PAIR && pon_r && ms_r == 8'd1 && hstep_r == 2'd2 &&
        pvalid_r) begin
      addr_r[pend_r] <= pa_r;
    end
    if (cmd.scan && op_r == OP_DATA && !hit_r && paired_r[idx_r] && addr_r[idx_r] == pa_r)
      seen_r[idx_r] <= now_r;
    if (cmd.finish && op_r == OP_PAIR && pon_r && pvalid_r && ms_r == 8'd2 &&
        hstep_r == 2'd3)
      seen_r[pend_r] <= now_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      paired_r <= '0; idx_r <= '0; total_r <= '0; pon_r <= 1'b0; hstep_r <= 2'd0;
      pend_r <= '0; pvalid_r <= 1'b0; mode_r <= MODE_CLOSED;
      ff_found_r <= 1'b0; ff_slot_r <= '0; hit_r <= 1'b0; hit_slot_r <= '0; rem_r <= '0;
      res_r <= '0;
    end else begin
      if (cmd.load) begin
        idx_r <= '0; ff_found_r <= 1'b0; hit_r <= 1'b0; rem_r <= '0;
      end
      if (cmd.scan) begin
        idx_r <= idx_r + SLOT_W'(1);
        paired_r <= paired_nxt;
        total_r <= total_nxt;
        if (!ff_found_r && !paired_r[idx_r]) begin
          ff_found_r <= 1'b1; ff_slot_r <= idx_r;
        end
        if (op_r == OP_DATA && !hit_r && paired_r[idx_r] && addr_r[idx_r] == pa_r) begin
          hit_r <= 1'b1; hit_slot_r <= idx_r;
        end
        if (idx_drop) begin
          rem_r <= rem_r + CNT_W'(1);
          if (op_r == OP_SWEEP)
            mode_r <= (total_nxt >= CNT_W'(TABLE_SIZE)) ? MODE_FULL : MODE_CLOSED;
        end
        // a step-one message with no pending slot takes the first free one
        if (op_r == OP_PAIR && pon_r && ms_r == 8'd1 && hstep_r == 2'd2 && !pvalid_r &&
            !ff_found_r && !paired_r[idx_r]) begin
          pvalid_r <= 1'b1; pend_r <= idx_r;
        end
      end
      if (cmd.finish) begin
        res_r <= res_nxt;
        case (op_r)
          OP_START: begin
            if (total_r >= CNT_W'(TABLE_SIZE)) begin
              mode_r <= MODE_FULL;
            end else if (!pon_r) begin
              if (ff_found_r) begin
                pend_r <= ff_slot_r; pvalid_r <= 1'b1;
              end
              pon_r <= 1'b1; hstep_r <= 2'd2; mode_r <= MODE_OPEN;
            end
          end
          OP_STOP: begin
            pon_r <= 1'b0; pvalid_r <= 1'b0;
            mode_r <= (total_r >= CNT_W'(TABLE_SIZE)) ? MODE_FULL : MODE_CLOSED;
          end
          OP_PAIR: begin
            if (pon_r && ms_r == 8'd1 && hstep_r == 2'd2) begin
              if (!pvalid_r) begin
                pon_r <= 1'b0; mode_r <= MODE_FULL;
              end else begin
                hstep_r <= 2'd3;
              end
            end else if (pon_r && ms_r == 8'd2 && hstep_r == 2'd3 && pvalid_r) begin
              if (!paired_r[pend_r]) total_r <= total_r + CNT_W'(1);
              paired_r[pend_r] <= 1'b1;
              pon_r <= 1'b0; pvalid_r <= 1'b0;
              mode_r <= ((total_r + CNT_W'(!paired_r[pend_r])) >= CNT_W'(TABLE_SIZE)) ?
                        MODE_FULL : MODE_CLOSED;
            end
          end
          OP_REMOVE: begin
            if (slot_ok && paired_r[sidx]) begin
              paired_r[sidx] <= 1'b0;
              total_r <= total_r - CNT_W'(1);
              mode_r <= MODE_CLOSED;
            end
          end
          OP_CLEAR: begin
            total_r <= '0; mode_r <= MODE_CLOSED;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// File: rtl/peer_pairing_table.sv
// Peer pairing table: master side of a three-step pairing handshake over a
// table of TABLE_SIZE peers.
// Channels: in_* takes one event item (op, peer_address, msg_step, slot_in,
// now_ms); out_* returns exactly one result item per event; cfg_* writes
// own_address (index 0) or activity_timeout (index 1). The user must write cfg_*
// only while the block idles; the block itself does not enforce this.
// Sequencing: an event that walks the table (start, pairing msg, data msg,
// remove all, sweep) goes from accept through the scan loop, one slot at a
// time, then the finish state before out_valid; other events skip the scan.
// Flow: one item at a time; the next item is accepted the cycle after the
// result is taken.
// Reset (rst_n low, synchronous): all entries unpaired, count zero, pairing
// off, mode closed, timeout 30000 ms, own address zero.
// Stall: a result holds on out_* until out_ready; no item is accepted meanwhile.
module peer_pairing_table
  import ppt_pkg::*;
(
  input logic clk,
  input logic rst_n,
  ppt_in_if.sink    in_ch,
  ppt_out_if.source out_ch,
  ppt_cfg_if.sink   cfg_ch
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  result_t res;
  logic [ADDR_W-1:0] own_addr_r;
  logic [TIME_W-1:0] timeout_r;

  // configuration is always accepted
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r <= '0;
      timeout_r  <= TIMEOUT_RESET;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == CFG_OWN_ADDR) own_addr_r <= cfg_ch.data;
      else timeout_r <= cfg_ch.data[TIME_W-1:0];
    end
  end

  ppt_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd, .sts
  );

  ppt_dp u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_op(in_ch.op), .in_addr(in_ch.peer_address), .in_step(in_ch.msg_step),
    .in_slot(in_ch.slot_in), .in_now(in_ch.now_ms), .timeout(timeout_r), .res
  );

  // own address rides in outgoing payloads, which are outside this port
  logic own_addr_used;
  assign own_addr_used = ^own_addr_r;

  assign out_ch.send_valid     = res.send_valid;
  assign out_ch.send_broadcast = res.send_broadcast;
  assign out_ch.send_dest      = res.send_dest;
  assign out_ch.send_step      = res.send_step;
  assign out_ch.status         = res.status;
  assign out_ch.pairing_state  = res.pairing_state;
  assign out_ch.peer_count     = res.peer_count;
  assign out_ch.slot_out       = res.slot_out;
  assign out_ch.removed_count  = res.removed_count;
  assign out_ch.slot_active    = res.slot_active;

`ifndef NO_ASSERTIONS
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("accept while result pending");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.peer_count <= 5'(TABLE_SIZE)) else $error("peer count overflow");
  a_bcast: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.send_broadcast |-> out_ch.send_step == 2'd1)
    else $error("broadcast not step one");
`endif

endmodule

// File: verif/ppt_tb_if.sv
`timescale 1ns / 100ps
// Channel interfaces come from the RTL (ppt_if.sv); nothing extra is needed here.
package ppt_tb_types;
  import ppt_pkg::*;
  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] peer_address;
    logic [7:0]        msg_step;
    logic [7:0]        slot_in;
    logic [TIME_W-1:0] now_ms;
  } event_item_t;
endpackage

// File: verif/peer_pairing_table_tb.sv
`timescale 1ns / 100ps
module peer_pairing_table_tb;
  import ppt_pkg::*;
  import ppt_tb_types::*;

  logic clk;
  logic rst_n;

  ppt_in_if  in_ch();
  ppt_out_if out_ch();
  ppt_cfg_if cfg_ch();

  peer_pairing_table u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  // Shadow copy of the peer table and pairing state.
  logic [ADDR_W-1:0] tbl_addr [TABLE_SIZE];
  logic              tbl_paired [TABLE_SIZE];
  logic [TIME_W-1:0] tbl_seen [TABLE_SIZE];
  int                paired_cnt;
  logic              pairing_en;
  int                hs_step;
  int                pend_slot;
  logic              pend_ok;
  mode_t             cur_mode;
  logic [ADDR_W-1:0] own_addr_reg;
  logic [TIME_W-1:0] timeout_reg;

  event_item_t event_queue[$];
  result_t     result_queue[$];
  int          err_cnt;
  int          item_cnt;
  int          result_cnt;
  int          op_seen [8];
  logic        quiet;      // no idling in the last part of the run
  logic        hold_input; // driver holds off while the block drains

  // Known peers, so data messages and pairing steps hit real entries.
  logic [ADDR_W-1:0] peer_pool [8];

  function automatic int first_free_slot();
    for (int i = 0; i < TABLE_SIZE; i++)
      if (!tbl_paired[i]) return i;
    return -1;
  endfunction

  function automatic mode_t mode_from_count();
    return (paired_cnt >= TABLE_SIZE) ? MODE_FULL : MODE_CLOSED;
  endfunction

  function automatic void drop_entry(int i);
    tbl_paired[i] = 1'b0;
    tbl_addr[i] = '0;
    tbl_seen[i] = '0;
    if (paired_cnt > 0) paired_cnt--;
  endfunction

  // Work out the one result an event causes and advance the shadow state.
  function automatic result_t pairing_outcome(event_item_t ev);
    result_t r;
    int f;
    int sl;
    logic [TIME_W-1:0] age;
    r = '0;
    sl = ev.slot_in;
    case (ev.op)
      OP_START: begin
        if (paired_cnt >= TABLE_SIZE) begin
          r.status = ST_FULL;
          cur_mode = MODE_FULL;
        end else if (pairing_en) begin
          r.status = ST_BUSY;
        end else begin
          f = first_free_slot();
          if (f >= 0) begin
            pend_slot = f;
            pend_ok = 1'b1;
            r.slot_out = f[3:0];
          end
          pairing_en = 1'b1;
          hs_step = 2;
          cur_mode = MODE_OPEN;
          r.send_valid = 1'b1;
          r.send_broadcast = 1'b1;
          r.send_dest = BCAST_ADDR;
          r.send_step = 2'd1;
        end
      end
      OP_STOP: begin
        pairing_en = 1'b0;
        pend_ok = 1'b0;
        cur_mode = mode_from_count();
      end
      OP_PAIR: begin
        if (!pairing_en) begin
          r.status = ST_IGNORED;
        end else if (ev.msg_step == 8'd1 && hs_step == 2) begin
          if (!pend_ok) begin
            f = first_free_slot();
            if (f >= 0) begin
              pend_slot = f;
              pend_ok = 1'b1;
            end
          end
          if (!pend_ok) begin
            pairing_en = 1'b0;
            cur_mode = MODE_FULL;
            r.status = ST_FULL;
          end else begin
            tbl_addr[pend_slot] = ev.peer_address;
            r.send_valid = 1'b1;
            r.send_dest = ev.peer_address;
            r.send_step = 2'd2;
            r.slot_out = pend_slot[3:0];
            hs_step = 3;
          end
        end else if (ev.msg_step == 8'd2 && hs_step == 3 && pend_ok) begin
          r.send_valid = 1'b1;
          r.send_dest = tbl_addr[pend_slot];
          r.send_step = 2'd3;
          r.slot_out = pend_slot[3:0];
          if (!tbl_paired[pend_slot]) paired_cnt++;
          tbl_paired[pend_slot] = 1'b1;
          tbl_seen[pend_slot] = ev.now_ms;
          pairing_en = 1'b0;
          cur_mode = mode_from_count();
          pend_ok = 1'b0;
        end else begin
          r.status = ST_IGNORED;
        end
      end
      OP_DATA: begin
        r.status = ST_IGNORED;
        for (int i = 0; i < TABLE_SIZE; i++) begin
          if (tbl_paired[i] && tbl_addr[i] == ev.peer_address) begin
            tbl_seen[i] = ev.now_ms;
            r.slot_out = i[3:0];
            r.status = ST_OK;
            break;
          end
        end
      end
      OP_REMOVE: begin
        r.slot_out = ev.slot_in[3:0];
        if (sl >= TABLE_SIZE) r.status = ST_BAD;
        else if (!tbl_paired[sl]) r.status = ST_UNPAIR;
        else begin
          drop_entry(sl);
          r.removed_count = CNT_W'(1);
          cur_mode = mode_from_count();
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < TABLE_SIZE; i++) begin
          if (tbl_paired[i]) begin
            drop_entry(i);
            r.removed_count++;
          end
        end
        paired_cnt = 0;
        cur_mode = MODE_CLOSED;
      end
      OP_SWEEP: begin
        for (int i = 0; i < TABLE_SIZE; i++) begin
          age = ev.now_ms - tbl_seen[i];
          if (tbl_paired[i] && !(age < timeout_reg)) begin
            drop_entry(i);
            r.removed_count++;
            cur_mode = mode_from_count();
          end
        end
      end
      default: begin
        r.slot_out = ev.slot_in[3:0];
        if (sl >= TABLE_SIZE) r.status = ST_BAD;
        else if (!tbl_paired[sl]) r.status = ST_UNPAIR;
        else begin
          age = ev.now_ms - tbl_seen[sl];
          r.slot_active = age < timeout_reg;
        end
      end
    endcase
    r.pairing_state = cur_mode;
    r.peer_count = paired_cnt[CNT_W-1:0];
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Driver: advance through the pending items, idling in random bursts.
  int in_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap <= 0;
    end else if (in_ch.valid && !in_ch.ready) begin
      // hold the current item until it is taken
    end else begin
      if (in_ch.valid) begin
        // item just taken: predict its result
        result_queue.push_back(pairing_outcome({op_t'(in_ch.op), in_ch.peer_address,
                                                in_ch.msg_step, in_ch.slot_in,
                                                in_ch.now_ms}));
        op_seen[in_ch.op]++;
        item_cnt++;
      end
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        in_gap <= $urandom_range(1, 13) - 1;
        in_ch.valid <= 1'b0;
      end else if (event_queue.size() > 0 && !hold_input) begin
        event_item_t ev;
        ev = event_queue.pop_front();
        in_ch.op <= ev.op;
        in_ch.peer_address <= ev.peer_address;
        in_ch.msg_step <= ev.msg_step;
        in_ch.slot_in <= ev.slot_in;
        in_ch.now_ms <= ev.now_ms;
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: take results, stalling in random bursts, and compare field by field.
  int out_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (result_queue.size() == 0) begin
          $error("result with nothing expected");
          err_cnt++;
        end else begin
          result_t e;
          e = result_queue.pop_front();
          result_cnt++;
          if (out_ch.send_valid !== e.send_valid) begin
            $error("send_valid exp %0h got %0h", e.send_valid, out_ch.send_valid);
            err_cnt++;
          end
          if (out_ch.send_broadcast !== e.send_broadcast) begin
            $error("send_broadcast exp %0h got %0h", e.send_broadcast, out_ch.send_broadcast);
            err_cnt++;
          end
          if (out_ch.send_dest !== e.send_dest) begin
            $error("send_dest exp %0h got %0h", e.send_dest, out_ch.send_dest);
            err_cnt++;
          end
          if (out_ch.send_step !== e.send_step) begin
            $error("send_step exp %0h got %0h", e.send_step, out_ch.send_step);
            err_cnt++;
          end
          if (out_ch.status !== e.status) begin
            $error("status exp %0h got %0h", e.status, out_ch.status);
            err_cnt++;
          end
          if (out_ch.pairing_state !== e.pairing_state) begin
            $error("pairing_state exp %0h got %0h", e.pairing_state, out_ch.pairing_state);
            err_cnt++;
          end
          if (out_ch.peer_count !== e.peer_count) begin
            $error("peer_count exp %0h got %0h", e.peer_count, out_ch.peer_count);
            err_cnt++;
          end
          if (out_ch.slot_out !== e.slot_out) begin
            $error("slot_out exp %0h got %0h", e.slot_out, out_ch.slot_out);
            err_cnt++;
          end
          if (out_ch.removed_count !== e.removed_count) begin
            $error("removed_count exp %0h got %0h", e.removed_count, out_ch.removed_count);
            err_cnt++;
          end
          if (out_ch.slot_active !== e.slot_active) begin
            $error("slot_active exp %0h got %0h", e.slot_active, out_ch.slot_active);
            err_cnt++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(1, 13) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Queue one event.
  task automatic add_event(op_t op, logic [ADDR_W-1:0] a, logic [7:0] st,
                           logic [7:0] sl, logic [TIME_W-1:0] t);
    event_queue.push_back({op, a, st, sl, t});
  endtask

  // Write one register through the config channel while the block is idle.
  task automatic write_reg(logic idx, logic [47:0] val);
    @(posedge clk);
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_OWN_ADDR) own_addr_reg = val;
    else timeout_reg = val[31:0];
  endtask

  // Drain: wait for queued items to go and every result to come, then settle.
  task automatic drain();
    while (event_queue.size() > 0 || in_ch.valid || result_queue.size() > 0)
      @(posedge clk);
    repeat (TABLE_SIZE + 8) @(posedge clk);
  endtask

  logic [TIME_W-1:0] clock_ms;

  // Mostly well-formed pairings with random content, plus noise.
  task automatic random_phase(int n);
    int k;
    int pick;
    logic [ADDR_W-1:0] a;
    k = 0;
    while (k < n) begin
      clock_ms += $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 20000);
      pick = $urandom_range(0, 99);
      a = $urandom_range(0, 3) == 0 ? ADDR_W'({$urandom, $urandom}) :
          peer_pool[$urandom_range(0, 7)];
      if (pick < 40) begin
        // full handshake, sometimes broken by a wrong step or a stop
        add_event(OP_START, a, 8'($urandom), 8'($urandom), clock_ms);
        add_event(OP_PAIR, a, 8'd1, 8'($urandom), clock_ms);
        if ($urandom_range(0, 7) == 0)
          add_event(OP_PAIR, a, $urandom_range(0, 1) ? 8'd1 : 8'($urandom), 8'($urandom),
                    clock_ms);
        if ($urandom_range(0, 9) == 0)
          add_event(OP_STOP, a, 8'($urandom), 8'($urandom), clock_ms);
        add_event(OP_PAIR, ADDR_W'({$urandom, $urandom}), 8'd2, 8'($urandom),
                  clock_ms + 32'd5);
        k += 3;
      end else if (pick < 60) begin
        add_event(OP_DATA, a, 8'($urandom), 8'($urandom), clock_ms);
        k++;
      end else if (pick < 75) begin
        add_event(OP_QUERY, a, 8'($urandom), $urandom_range(0, 3) == 0 ? 8'($urandom) :
                  8'($urandom_range(0, TABLE_SIZE - 1)), clock_ms);
        k++;
      end else if (pick < 83) begin
        add_event(OP_REMOVE, a, 8'($urandom), $urandom_range(0, 4) == 0 ? 8'($urandom) :
                  8'($urandom_range(0, TABLE_SIZE - 1)), clock_ms);
        k++;
      end else if (pick < 90) begin
        add_event(OP_SWEEP, a, 8'($urandom), 8'($urandom), clock_ms);
        k++;
      end else begin
        add_event(op_t'($urandom_range(0, 7)), a, 8'($urandom), 8'($urandom), $urandom);
        k++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_START;
    in_ch.peer_address = '0;
    in_ch.msg_step = '0;
    in_ch.slot_in = '0;
    in_ch.now_ms = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_OWN_ADDR;
    cfg_ch.data = '0;
    err_cnt = 0;
    item_cnt = 0;
    result_cnt = 0;
    quiet = 1'b0;
    hold_input = 1'b0;
    clock_ms = '0;
    paired_cnt = 0;
    pairing_en = 1'b0;
    hs_step = 0;
    pend_slot = 0;
    pend_ok = 1'b0;
    cur_mode = MODE_CLOSED;
    own_addr_reg = '0;
    timeout_reg = TIMEOUT_RESET;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      tbl_addr[i] = '0;
      tbl_paired[i] = 1'b0;
      tbl_seen[i] = '0;
    end
    for (int i = 0; i < 8; i++) peer_pool[i] = ADDR_W'({$urandom, $urandom});
    peer_pool[0] = '0;
    peer_pool[1] = BCAST_ADDR;
    for (int i = 0; i < 8; i++) op_seen[i] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: ignored pairing msg, every op, bad slots, field extremes.
    write_reg(CFG_OWN_ADDR, 48'hFFFF_FFFF_FFFF);
    add_event(OP_PAIR, '0, 8'd1, 8'd0, 32'd0);
    add_event(OP_STOP, '0, 8'd0, 8'd0, 32'd0);
    add_event(OP_START, '0, 8'd0, 8'd0, 32'd0);
    add_event(OP_START, '0, 8'd0, 8'd0, 32'd0);     // already pairing
    add_event(OP_PAIR, BCAST_ADDR, 8'd2, 8'd0, 32'd0);  // wrong step
    add_event(OP_PAIR, BCAST_ADDR, 8'd1, 8'd0, 32'd0);
    add_event(OP_PAIR, '0, 8'd255, 8'd255, 32'hFFFF_FFFF);
    add_event(OP_PAIR, '0, 8'd2, 8'd0, 32'hFFFF_FFFF);
    add_event(OP_DATA, BCAST_ADDR, 8'd0, 8'd0, 32'd10);
    add_event(OP_DATA, 48'h1234, 8'd0, 8'd0, 32'd10);  // no match
    add_event(OP_QUERY, '0, 8'd0, 8'd0, 32'd100);
    add_event(OP_QUERY, '0, 8'd0, 8'd255, 32'd100);
    add_event(OP_QUERY, '0, 8'd0, 8'd15, 32'd100);
    add_event(OP_REMOVE, '0, 8'd0, 8'd16, 32'd0);
    add_event(OP_REMOVE, '0, 8'd0, 8'd5, 32'd0);
    add_event(OP_SWEEP, '0, 8'd0, 8'd0, 32'd40000);   // times out the peer
    add_event(OP_CLEAR, '0, 8'd0, 8'd0, 32'd0);
    drain();

    // Fill the table completely to reach the full state.
    write_reg(CFG_TIMEOUT, 48'hFFFF_FFFF);
    write_reg(CFG_OWN_ADDR, 48'h0);
    for (int i = 0; i < TABLE_SIZE; i++) begin
      add_event(OP_START, '0, 8'd0, 8'd0, TIME_W'(i));
      add_event(OP_PAIR, ADDR_W'({$urandom, $urandom}), 8'd1, 8'd0, TIME_W'(i));
      add_event(OP_PAIR, '0, 8'd2, 8'd0, TIME_W'(i));
    end
    add_event(OP_START, '0, 8'd0, 8'd0, 32'd0);       // table full
    add_event(OP_REMOVE, '0, 8'd0, 8'd3, 32'd0);
    add_event(OP_START, '0, 8'd0, 8'd0, 32'd0);
    add_event(OP_QUERY, '0, 8'd0, 8'd4, 32'd7);
    add_event(OP_SWEEP, '0, 8'd0, 8'd0, 32'd3);
    add_event(OP_CLEAR, '0, 8'd0, 8'd0, 32'd0);
    drain();

    // Random phases under several timeout settings; the driver holds off
    // between them until every result is in.
    write_reg(CFG_TIMEOUT, 48'd0);
    random_phase(300);
    drain();
    write_reg(CFG_TIMEOUT, 48'd50000);
    write_reg(CFG_OWN_ADDR, ADDR_W'({$urandom, $urandom}));
    random_phase(400);
    drain();
    write_reg(CFG_TIMEOUT, 48'd1);
    random_phase(250);
    hold_input = 1'b1;
    while (result_queue.size() > 0 || in_ch.valid) @(posedge clk);
    hold_input = 1'b0;
    random_phase(150);
    drain();
    write_reg(CFG_TIMEOUT, 48'hFFFF_FFFF);
    quiet = 1'b1;
    random_phase(220);
    drain();

    $display("covered %0d events (%0d start, %0d pairing msgs, %0d data, %0d sweep)",
             item_cnt, op_seen[OP_START], op_seen[OP_PAIR], op_seen[OP_DATA],
             op_seen[OP_SWEEP]);
    $display("results checked: %0d, mismatches: %0d", result_cnt, err_cnt);
    if (err_cnt == 0 && result_queue.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
